// File: src/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test package
// Microcode step names, control word layout, the program ROM and constants
// shared by the interfaces and the top level.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // The prime count has a fixed width, independent of the candidate width.
  localparam int unsigned TALLY_WIDTH = 16;
  localparam logic [TALLY_WIDTH-1:0] TALLY_MAX = '1;

  // First trial divisor.
  localparam int unsigned FIRST_DIVISOR = 2;

  // Program addresses.
  typedef enum logic [3:0] {
    STEP_IDLE    = 4'd0,
    STEP_SMALL   = 4'd1,
    STEP_CHECK   = 4'd2,
    STEP_DIVINIT = 4'd3,
    STEP_DIVSTEP = 4'd4,
    STEP_REMTEST = 4'd5,
    STEP_NEXTD   = 4'd6,
    STEP_PRIME   = 4'd7,
    STEP_NOTP    = 4'd8,
    STEP_EMIT    = 4'd9
  } step_t;

  // Datapath actions.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_NEXTD,
    OP_PRIME,
    OP_NOTP,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_HAVE_INPUT,
    COND_LT_TWO,
    COND_SQ_GT_N,
    COND_DIV_MORE,
    COND_REM_ZERO,
    COND_OUT_FREE
  } cond_t;

  // One control word: the action, the jump condition and target, and
  // whether a false condition holds the step instead of falling through.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  stay;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    unique case (step)
      STEP_IDLE:    cw = '{op: OP_LOAD,    cond: COND_HAVE_INPUT, target: STEP_SMALL,
                           stay: 1'b1};
      STEP_SMALL:   cw = '{op: OP_NONE,    cond: COND_LT_TWO,     target: STEP_NOTP,
                           stay: 1'b0};
      STEP_CHECK:   cw = '{op: OP_NONE,    cond: COND_SQ_GT_N,    target: STEP_PRIME,
                           stay: 1'b0};
      STEP_DIVINIT: cw = '{op: OP_DIVINIT, cond: COND_ALWAYS,     target: STEP_DIVSTEP,
                           stay: 1'b0};
      STEP_DIVSTEP: cw = '{op: OP_DIVSTEP, cond: COND_DIV_MORE,   target: STEP_DIVSTEP,
                           stay: 1'b0};
      STEP_REMTEST: cw = '{op: OP_NONE,    cond: COND_REM_ZERO,   target: STEP_NOTP,
                           stay: 1'b0};
      STEP_NEXTD:   cw = '{op: OP_NEXTD,   cond: COND_ALWAYS,     target: STEP_CHECK,
                           stay: 1'b0};
      STEP_PRIME:   cw = '{op: OP_PRIME,   cond: COND_ALWAYS,     target: STEP_EMIT,
                           stay: 1'b0};
      STEP_NOTP:    cw = '{op: OP_NOTP,    cond: COND_ALWAYS,     target: STEP_EMIT,
                           stay: 1'b0};
      STEP_EMIT:    cw = '{op: OP_EMIT,    cond: COND_OUT_FREE,   target: STEP_IDLE,
                           stay: 1'b1};
      default:      cw = '{op: OP_NONE,    cond: COND_ALWAYS,     target: STEP_IDLE,
                           stay: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

// File: src/tdpt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test channels
// Valid/ready channels for candidates and for test results.
// ----------------------------------------------------------------------------
interface tdpt_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;
  logic                   first_in_range;
  logic                   last_in_range;

  modport source (output valid, candidate, first_in_range, last_in_range, input ready);
  modport sink   (input valid, candidate, first_in_range, last_in_range, output ready);
endinterface

interface tdpt_out_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic [VALUE_WIDTH-1:0]              tested_value;
  logic                                is_prime;
  logic [tdpt_pkg::TALLY_WIDTH-1:0]    primes_so_far;
  logic                                range_done;

  modport source (output valid, tested_value, is_prime, primes_so_far, range_done,
                  input ready);
  modport sink   (input valid, tested_value, is_prime, primes_so_far, range_done,
                  output ready);
endinterface

// File: src/trial_division_prime_test.sv
`timescale 1ns / 1ps
// The sequencer tries k trial divisors per candidate, where k is at most
// floor(sqrt(candidate)) - 1; each trial is a bit-serial remainder plus four
// sequencer steps. The block tests one candidate at a time; the next candidate
// can be taken in the cycle after the result is loaded, while that result waits
// in the output register.
// Synchronous active-low reset idles the sequencer, empties the output, clears count.
// ----------------------------------------------------------------------------
// Trial division prime test
// Microcoded sequencer that tests each candidate by trial division and keeps
// a saturating count of primes found in the current range.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tdpt_in_if.sink   in_ch,
  tdpt_out_if.source out_ch
);

  localparam int unsigned CNT_WIDTH = $clog2(VALUE_WIDTH);
  localparam int unsigned SQ_WIDTH  = VALUE_WIDTH + 2;
  localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(VALUE_WIDTH - 1);

  // Sequencer state.
  tdpt_pkg::step_t      step_r, step_nxt;
  tdpt_pkg::ctrl_word_t cw;
  logic                 cond_true;

  // Datapath registers. The candidate is n_r; the divisor d_r and its
  // square sq_r advance together so no multiplier is needed.
  logic [VALUE_WIDTH-1:0]           n_r;
  logic [VALUE_WIDTH-1:0]           d_r;
  logic [SQ_WIDTH-1:0]              sq_r;
  logic [VALUE_WIDTH-1:0]           rem_r;
  logic [VALUE_WIDTH-1:0]           quo_r;
  logic [CNT_WIDTH-1:0]             cnt_r;
  logic                             last_r;
  logic                             prime_r;
  logic [tdpt_pkg::TALLY_WIDTH-1:0] tally_r;

  // Output register.
  logic                             out_valid_r;
  logic [VALUE_WIDTH-1:0]           out_value_r;
  logic                             out_prime_r;
  logic [tdpt_pkg::TALLY_WIDTH-1:0] out_tally_r;
  logic                             out_done_r;

  logic                             in_xfer;
  logic                             out_free;
  logic [VALUE_WIDTH:0]             rem_shift;
  logic [VALUE_WIDTH:0]             rem_diff;

  // A new candidate is only taken in the idle step.
  assign in_ch.ready = (step_r == tdpt_pkg::STEP_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // The output register can be loaded when it is empty or being drained.
  assign out_free = !out_valid_r || out_ch.ready;

  // One restoring division step: shift in the next candidate bit, then
  // subtract the divisor when it fits.
  assign rem_shift = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, d_r};

  // Control word fetch.
  always_comb begin
    cw = tdpt_pkg::ucode_rom(step_r);
  end

  // Condition evaluation and next step.
  always_comb begin
    unique case (cw.cond)
      tdpt_pkg::COND_ALWAYS:     cond_true = 1'b1;
      tdpt_pkg::COND_HAVE_INPUT: cond_true = in_ch.valid;
      tdpt_pkg::COND_LT_TWO:     cond_true = (n_r < VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR));
      tdpt_pkg::COND_SQ_GT_N:    cond_true = (sq_r > {2'b00, n_r});
      tdpt_pkg::COND_DIV_MORE:   cond_true = (cnt_r != '0);
      tdpt_pkg::COND_REM_ZERO:   cond_true = (rem_r == '0);
      tdpt_pkg::COND_OUT_FREE:   cond_true = out_free;
      default:                   cond_true = 1'b0;
    endcase

    priority if (cond_true) begin
      step_nxt = cw.target;
    end else if (cw.stay) begin
      step_nxt = step_r;
    end else begin
      step_nxt = tdpt_pkg::step_t'(step_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= tdpt_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Datapath, driven by the op field of the current control word.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      tdpt_pkg::OP_LOAD: begin
        if (in_xfer) begin
          n_r    <= in_ch.candidate;
          last_r <= in_ch.last_in_range;
          d_r    <= VALUE_WIDTH'(tdpt_pkg::FIRST_DIVISOR);
          sq_r   <= SQ_WIDTH'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
        end
      end
      tdpt_pkg::OP_DIVINIT: begin
        rem_r <= '0;
        quo_r <= n_r;
        cnt_r <= CNT_LAST;
      end
      tdpt_pkg::OP_DIVSTEP: begin
        if (!rem_diff[VALUE_WIDTH]) begin
          rem_r <= rem_diff[VALUE_WIDTH-1:0];
        end else begin
          rem_r <= rem_shift[VALUE_WIDTH-1:0];
        end
        quo_r <= {quo_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
      end
      tdpt_pkg::OP_NEXTD: begin
        // (d + 1)^2 = d^2 + 2d + 1
        d_r  <= d_r + 1'b1;
        sq_r <= sq_r + {1'b0, d_r, 1'b1};
      end
      tdpt_pkg::OP_PRIME: prime_r <= 1'b1;
      tdpt_pkg::OP_NOTP:  prime_r <= 1'b0;
      default: begin
      end
    endcase
  end

  // Running prime count: cleared by reset or by a start-of-range mark on the
  // transfer, bumped on each prime until it saturates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else if (cw.op == tdpt_pkg::OP_LOAD && in_xfer && in_ch.first_in_range) begin
      tally_r <= '0;
    end else if (cw.op == tdpt_pkg::OP_PRIME && tally_r != tdpt_pkg::TALLY_MAX) begin
      tally_r <= tally_r + 1'b1;
    end
  end

  // Output register. The count loaded here already includes this candidate,
  // since the prime step has already updated it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.op == tdpt_pkg::OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == tdpt_pkg::OP_EMIT && out_free) begin
      out_value_r <= n_r;
      out_prime_r <= prime_r;
      out_tally_r <= tally_r;
      out_done_r  <= last_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tested_value  = out_value_r;
  assign out_ch.is_prime      = out_prime_r;
  assign out_ch.primes_so_far = out_tally_r;
  assign out_ch.range_done    = out_done_r;

endmodule
